[sv/pmms_pkg.sv]
package pmms_pkg;

    localparam int CountBits   = 32;
    localparam int DutyBits    = 11;
    localparam int IntegBits   = 21;
    localparam int IntegMax    = 1048575;
    localparam int CmdMax      = (1 << DutyBits) - 1;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 16;

    localparam logic [CfgIdxBits-1:0] CfgFastSpeed = 3'd0;
    localparam logic [CfgIdxBits-1:0] CfgSlowSpeed = 3'd1;
    localparam logic [CfgIdxBits-1:0] CfgSlowPoint = 3'd2;
    localparam logic [CfgIdxBits-1:0] CfgStopPoint = 3'd3;
    localparam logic [CfgIdxBits-1:0] CfgHoldTicks = 3'd4;

    typedef enum logic [2:0] {
        ModeIdle    = 3'd0,
        ModeArmed   = 3'd1,
        ModeFwdFast = 3'd2,
        ModeFwdSlow = 3'd3,
        ModeRevFast = 3'd4,
        ModeRevSlow = 3'd5
    } mode_t;

    typedef struct packed {
        logic [6:0]  fast_speed;
        logic [6:0]  slow_speed;
        logic [15:0] slow_point;
        logic [15:0] stop_point;
        logic [9:0]  hold_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [8:0] gain_p;
        logic [7:0] gain_i;
        logic       clr_integ;
    } seq_ctl_t;

endpackage

[sv/pmms_seq.sv]
module pmms_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  pmms_pkg::cfg_t                   cfg,
    input  logic [pmms_pkg::CountBits-1:0]   enc,
    input  logic [11:0]                      pot,
    input  logic                             start,
    input  logic                             fwd,
    input  logic                             rev,
    output pmms_pkg::seq_ctl_t               ctl
);

    pmms_pkg::mode_t                  mode_reg, mode_next;
    logic [9:0]                       hold_count_reg, hold_count_next;
    logic [pmms_pkg::CountBits-1:0]   origin_reg, origin_next;
    logic [8:0]                       gain_p_reg, gain_p_next;
    logic [7:0]                       gain_i_reg, gain_i_next;
    logic                             clr_integ;

    logic signed [pmms_pkg::CountBits-1:0] pos;
    logic signed [32:0]               pos_ext;
    logic signed [32:0]               slow_ext;
    logic signed [32:0]               stop_ext;
    logic [20:0]                      prod_p;
    logic [18:0]                      prod_i;
    logic [8:0]                       gain_p_calc;
    logic [7:0]                       gain_i_calc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= pmms_pkg::ModeIdle;
            hold_count_reg <= '0;
            origin_reg     <= '0;
            gain_p_reg     <= 9'd100;
            gain_i_reg     <= 8'd40;
        end else if (step) begin
            mode_reg       <= mode_next;
            hold_count_reg <= hold_count_next;
            origin_reg     <= origin_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
        end
    end

    always_comb begin
        pos         = enc - origin_reg;
        pos_ext     = 33'(pos);
        slow_ext    = $signed({17'b0, cfg.slow_point});
        stop_ext    = $signed({17'b0, cfg.stop_point});
        prod_p      = 21'(pot) * 21'd400;
        prod_i      = 19'(pot) * 19'd100;
        gain_p_calc = prod_p[20:12] + 9'd100;
        gain_i_calc = {1'b0, prod_i[18:12]} + 8'd40;

        mode_next       = mode_reg;
        hold_count_next = hold_count_reg;
        origin_next     = origin_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        clr_integ       = 1'b0;

        unique case (mode_reg)
            pmms_pkg::ModeIdle: begin
                if (hold_count_reg != 10'd0) begin
                    hold_count_next = hold_count_reg - 10'd1;
                end else begin
                    origin_next = enc;
                    gain_p_next = gain_p_calc;
                    if (start) begin
                        mode_next = pmms_pkg::ModeArmed;
                    end
                end
            end
            pmms_pkg::ModeArmed: begin
                gain_i_next = gain_i_calc;
                if (rev) begin
                    mode_next = pmms_pkg::ModeRevFast;
                end else if (fwd) begin
                    mode_next = pmms_pkg::ModeFwdFast;
                end
            end
            pmms_pkg::ModeFwdFast: begin
                if (pos_ext > slow_ext) begin
                    mode_next = pmms_pkg::ModeFwdSlow;
                end
            end
            pmms_pkg::ModeFwdSlow: begin
                if (pos_ext > stop_ext) begin
                    mode_next       = pmms_pkg::ModeIdle;
                    hold_count_next = cfg.hold_ticks;
                    clr_integ       = 1'b1;
                end
            end
            pmms_pkg::ModeRevFast: begin
                if (pos_ext < -slow_ext) begin
                    mode_next = pmms_pkg::ModeRevSlow;
                end
            end
            pmms_pkg::ModeRevSlow: begin
                if (pos_ext < -stop_ext) begin
                    mode_next       = pmms_pkg::ModeIdle;
                    hold_count_next = cfg.hold_ticks;
                    clr_integ       = 1'b1;
                end
            end
            default: begin
                mode_next = pmms_pkg::ModeIdle;
            end
        endcase

        ctl.mode      = mode_next;
        ctl.gain_p    = gain_p_next;
        ctl.gain_i    = gain_i_next;
        ctl.clr_integ = clr_integ;
    end

    a_hold_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_count_reg != 10'd0 |-> mode_reg == pmms_pkg::ModeIdle)
        else $error("hold count running outside idle");

    a_hold_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == pmms_pkg::ModeIdle && hold_count_reg != 10'd0
        |=> hold_count_reg == $past(hold_count_reg) - 10'd1)
        else $error("hold count did not count down");

    a_armed_exits: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == pmms_pkg::ModeArmed
        |=> mode_reg == pmms_pkg::ModeArmed || mode_reg == pmms_pkg::ModeFwdFast
            || mode_reg == pmms_pkg::ModeRevFast)
        else $error("illegal exit from armed");

endmodule

[sv/pmms_pi.sv]
module pmms_pi (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  pmms_pkg::cfg_t                   cfg,
    input  logic [pmms_pkg::CountBits-1:0]   enc,
    input  pmms_pkg::seq_ctl_t               ctl,
    output logic                             direction,
    output logic [pmms_pkg::DutyBits-1:0]    duty,
    output logic signed [15:0]               speed
);

    localparam logic signed [21:0] IntegHi  = 22'(pmms_pkg::IntegMax);
    localparam logic signed [21:0] IntegLo  = -22'(pmms_pkg::IntegMax);
    localparam logic signed [31:0] CmdLimit = 32'(pmms_pkg::CmdMax);

    logic [pmms_pkg::CountBits-1:0]          last_reg;
    logic signed [pmms_pkg::IntegBits-1:0]   integ_reg;

    logic signed [pmms_pkg::CountBits-1:0]   diff;
    logic signed [32:0]                      diff_ext;
    logic signed [7:0]                       setp;
    logic signed [16:0]                      err;
    logic signed [pmms_pkg::IntegBits-1:0]   integ_base;
    logic signed [21:0]                      integ_sum;
    logic signed [pmms_pkg::IntegBits-1:0]   integ_new;
    logic signed [9:0]                       gp_s;
    logic signed [8:0]                       gi_s;
    logic signed [26:0]                      prod_p;
    logic signed [29:0]                      prod_i;
    logic signed [31:0]                      cmd;
    logic signed [31:0]                      cmd_neg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            integ_reg <= '0;
        end else if (step) begin
            last_reg  <= enc;
            integ_reg <= integ_new;
        end
    end

    always_comb begin
        diff     = enc - last_reg;
        diff_ext = 33'(diff);
        if (diff_ext > 33'sd32767) begin
            speed = 16'sh7FFF;
        end else if (diff_ext < -33'sd32768) begin
            speed = 16'sh8000;
        end else begin
            speed = diff_ext[15:0];
        end

        case (ctl.mode)
            pmms_pkg::ModeFwdFast: setp = $signed({1'b0, cfg.fast_speed});
            pmms_pkg::ModeFwdSlow: setp = $signed({1'b0, cfg.slow_speed});
            pmms_pkg::ModeRevFast: setp = -$signed({1'b0, cfg.fast_speed});
            pmms_pkg::ModeRevSlow: setp = -$signed({1'b0, cfg.slow_speed});
            default:               setp = 8'sd0;
        endcase

        err        = 17'(setp) - 17'(speed);
        integ_base = ctl.clr_integ ? '0 : integ_reg;
        integ_sum  = 22'(integ_base) + 22'(err);
        if (integ_sum > IntegHi) begin
            integ_new = IntegHi[pmms_pkg::IntegBits-1:0];
        end else if (integ_sum < IntegLo) begin
            integ_new = IntegLo[pmms_pkg::IntegBits-1:0];
        end else begin
            integ_new = integ_sum[pmms_pkg::IntegBits-1:0];
        end

        gp_s    = $signed({1'b0, ctl.gain_p});
        gi_s    = $signed({1'b0, ctl.gain_i});
        prod_p  = gp_s * err;
        prod_i  = gi_s * integ_new;
        cmd     = 32'(prod_p) + 32'(prod_i);
        cmd_neg = -cmd;

        if (cmd > CmdLimit) begin
            direction = 1'b1;
            duty      = CmdLimit[pmms_pkg::DutyBits-1:0];
        end else if (cmd < -CmdLimit) begin
            direction = 1'b0;
            duty      = CmdLimit[pmms_pkg::DutyBits-1:0];
        end else if (cmd > 32'sd0) begin
            direction = 1'b1;
            duty      = cmd[pmms_pkg::DutyBits-1:0];
        end else begin
            direction = 1'b0;
            duty      = cmd_neg[pmms_pkg::DutyBits-1:0];
        end
    end

endmodule

[sv/pi_motor_move_sequencer.sv]
// Motor move sequencer with a PI speed loop; each request is one control tick.
// The input channel (s_ prefix) carries the encoder count, a potentiometer sample
// and the three button flags. The result channel (m_ prefix) returns exactly one
// request per tick: direction, duty, sequencer mode, measured speed and both gains.
// Set-points, slow and stop distances and the hold time are written through the
// configuration port; writes take effect at once. Writes must be made while the
// block idles; the block itself does not enforce this. An accepted request is
// registered and processed by a single combinational pass through the sequencer
// and the PI arithmetic into the result register once that is free, raising m_valid.
// One request is accepted every cycle while results are taken; the pass is the limit.
// While the receiver stalls, the result register holds and the input register takes
// one more request, after which s_ready falls until the result is taken.
// Synchronous reset sets the sequencer to idle, clears the position and speed history
// and the integrator, restores the default gains and configuration, and empties both
// registers.
module pi_motor_move_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_encoder_count,
    input  logic [11:0]                         s_pot_sample,
    input  logic                                s_start_pressed,
    input  logic                                s_forward_pressed,
    input  logic                                s_reverse_pressed,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_direction,
    output logic [pmms_pkg::DutyBits-1:0]       m_duty,
    output logic [2:0]                          m_mode,
    output logic signed [15:0]                  m_speed,
    output logic [8:0]                          m_prop_gain,
    output logic [7:0]                          m_int_gain,
    input  logic                                cfg_wr_en,
    input  logic [pmms_pkg::CfgIdxBits-1:0]     cfg_index,
    input  logic [pmms_pkg::CfgDataBits-1:0]    cfg_data
);

    pmms_pkg::cfg_t                  cfg_reg;

    logic                            in_valid_reg;
    logic [pmms_pkg::CountBits-1:0]  in_count_reg;
    logic [11:0]                     in_pot_reg;
    logic                            in_start_reg;
    logic                            in_fwd_reg;
    logic                            in_rev_reg;

    logic                            out_valid_reg;
    logic                            out_dir_reg;
    logic [pmms_pkg::DutyBits-1:0]   out_duty_reg;
    logic [2:0]                      out_mode_reg;
    logic signed [15:0]              out_speed_reg;
    logic [8:0]                      out_gain_p_reg;
    logic [7:0]                      out_gain_i_reg;

    logic                            load;
    pmms_pkg::seq_ctl_t              ctl;
    logic                            pi_dir;
    logic [pmms_pkg::DutyBits-1:0]   pi_duty;
    logic signed [15:0]              pi_speed;

    assign load    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_speed <= 7'd7;
            cfg_reg.slow_speed <= 7'd4;
            cfg_reg.slow_point <= 16'd750;
            cfg_reg.stop_point <= 16'd810;
            cfg_reg.hold_ticks <= 10'd50;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pmms_pkg::CfgFastSpeed: cfg_reg.fast_speed <= cfg_data[6:0];
                pmms_pkg::CfgSlowSpeed: cfg_reg.slow_speed <= cfg_data[6:0];
                pmms_pkg::CfgSlowPoint: cfg_reg.slow_point <= cfg_data;
                pmms_pkg::CfgStopPoint: cfg_reg.stop_point <= cfg_data;
                pmms_pkg::CfgHoldTicks: cfg_reg.hold_ticks <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_count_reg <= s_encoder_count[pmms_pkg::CountBits-1:0];
            in_pot_reg   <= s_pot_sample;
            in_start_reg <= s_start_pressed;
            in_fwd_reg   <= s_forward_pressed;
            in_rev_reg   <= s_reverse_pressed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_dir_reg    <= pi_dir;
            out_duty_reg   <= pi_duty;
            out_mode_reg   <= ctl.mode;
            out_speed_reg  <= pi_speed;
            out_gain_p_reg <= ctl.gain_p;
            out_gain_i_reg <= ctl.gain_i;
        end
    end

    pmms_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (load),
        .cfg     (cfg_reg),
        .enc     (in_count_reg),
        .pot     (in_pot_reg),
        .start   (in_start_reg),
        .fwd     (in_fwd_reg),
        .rev     (in_rev_reg),
        .ctl     (ctl)
    );

    pmms_pi u_pi (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (load),
        .cfg       (cfg_reg),
        .enc       (in_count_reg),
        .ctl       (ctl),
        .direction (pi_dir),
        .duty      (pi_duty),
        .speed     (pi_speed)
    );

    assign m_valid     = out_valid_reg;
    assign m_direction = out_dir_reg;
    assign m_duty      = out_duty_reg;
    assign m_mode      = out_mode_reg;
    assign m_speed     = out_speed_reg;
    assign m_prop_gain = out_gain_p_reg;
    assign m_int_gain  = out_gain_i_reg;

    a_dir_needs_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_dir_reg |-> out_duty_reg != '0)
        else $error("positive direction with zero duty");

    a_load_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> out_valid_reg)
        else $error("processed request did not reach the result register");

endmodule
